/* sv/bqy_pkg.sv */
// Shared types, constants and the quad split function for the Bayer quad to YCC transform.
package bqy_pkg;

  localparam int PIX_W  = 12;
  localparam int CHR_W  = PIX_W + 1;
  localparam int LUMA_W = PIX_W + 2;

  // cfa_pattern bit positions
  localparam int CFA_GREEN_FIRST = 0;
  localparam int CFA_BLUE_FIRST  = 1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [1:0]       cfa_t;

  typedef struct packed {
    pix_t tl;
    pix_t tr;
    pix_t bl;
    pix_t br;
  } quad_t;

  typedef struct packed {
    pix_t r;
    pix_t g1;
    pix_t b;
    pix_t g2;
  } rgb_t;

  // One result to compute: colours plus the green each one is averaged with
  typedef struct packed {
    pix_t r;
    pix_t g1;
    pix_t b;
    pix_t g2;
    pix_t n1;
    pix_t n2;
    logic last;
  } job_t;

  typedef struct packed {
    logic pending;
    logic hold;
  } front_stat_t;

  function automatic rgb_t split_quad(quad_t q, cfa_t cfa);
    pix_t a0, a1, c0, c1;
    rgb_t s;
    if (cfa[CFA_BLUE_FIRST]) begin
      a0 = q.bl; a1 = q.br; c0 = q.tl; c1 = q.tr;
    end else begin
      a0 = q.tl; a1 = q.tr; c0 = q.bl; c1 = q.br;
    end
    if (cfa[CFA_GREEN_FIRST]) begin
      s.g1 = a0; s.r = a1; s.b = c0; s.g2 = c1;
    end else begin
      s.r = a0; s.g1 = a1; s.g2 = c0; s.b = c1;
    end
    return s;
  endfunction

endpackage

/* sv/bqy_front.sv */
// Front end: holds the pending quad, picks neighbour greens, and issues jobs for pending and row-end quads.
module bqy_front import bqy_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfa_t        cfa,
  input  logic        in_valid,
  output logic        in_ready,
  input  quad_t       in_quad,
  input  logic        in_row_end,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job,
  output front_stat_t stat
);

  quad_t pend_r;
  logic  pend_valid_r;
  logic  pend_first_r;
  pix_t  left_g_r;
  job_t  hold_r;
  logic  hold_valid_r;

  rgb_t  sp, sn;
  logic  gf, acc;
  pix_t  lg_pend;
  job_t  job_a, job_b;

  always_comb begin
    gf      = cfa[CFA_GREEN_FIRST];
    sp      = split_quad(pend_r, cfa);
    sn      = split_quad(in_quad, cfa);
    lg_pend = gf ? sp.g2 : sp.g1;

    // pending quad, right neighbour is the incoming quad
    job_a.r    = sp.r;
    job_a.g1   = sp.g1;
    job_a.b    = sp.b;
    job_a.g2   = sp.g2;
    job_a.n1   = gf ? sn.g1 : (pend_first_r ? sp.g1 : left_g_r);
    job_a.n2   = gf ? (pend_first_r ? sp.g2 : left_g_r) : sn.g2;
    job_a.last = 1'b0;

    // row-end quad, no right neighbour
    job_b.r    = sn.r;
    job_b.g1   = sn.g1;
    job_b.b    = sn.b;
    job_b.g2   = sn.g2;
    job_b.n1   = (!gf && pend_valid_r) ? lg_pend : sn.g1;
    job_b.n2   = (gf && pend_valid_r) ? lg_pend : sn.g2;
    job_b.last = 1'b1;
  end

  assign in_ready  = !hold_valid_r && job_ready;
  assign acc       = in_valid && in_ready;
  assign job_valid = hold_valid_r || (in_valid && (pend_valid_r || in_row_end));
  assign job       = hold_valid_r ? hold_r : (pend_valid_r ? job_a : job_b);
  assign stat      = '{pending: pend_valid_r, hold: hold_valid_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_first_r <= 1'b1;
      hold_valid_r <= 1'b0;
    end else begin
      if (hold_valid_r && job_ready) begin
        hold_valid_r <= 1'b0;
      end
      if (acc) begin
        if (in_row_end) begin
          pend_valid_r <= 1'b0;
          pend_first_r <= 1'b1;
          // second result of a row-end transfer is parked in hold_r until job_ready takes it
          hold_valid_r <= pend_valid_r;
        end else begin
          pend_valid_r <= 1'b1;
          pend_first_r <= !pend_valid_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_r <= in_quad;
      hold_r <= job_b;
      if (pend_valid_r) begin
        left_g_r <= lg_pend;
      end
    end
  end

endmodule

/* sv/bqy_queue.sv */
// Two-entry job queue between front and back end.
module bqy_queue import bqy_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_job   = ent_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

/* sv/bqy_back.sv */
// Back end: two-stage arithmetic for Cr, Cb, dG and Y with a registered output.
module bqy_back import bqy_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  output logic                     job_ready,
  input  job_t                     job,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [LUMA_W-1:0] out_luma,
  output logic signed [CHR_W-1:0]  out_green_diff,
  output logic signed [CHR_W-1:0]  out_chroma_red,
  output logic signed [CHR_W-1:0]  out_chroma_blue,
  output logic                     out_last_of_row
);

  // stage 1
  logic                    s1_valid_r;
  logic signed [CHR_W-1:0] s1_cr_r, s1_cb_r, s1_dg_r;
  pix_t                    s1_g1_r;
  logic                    s1_last_r;

  // output stage
  logic                     o_valid_r;
  logic signed [LUMA_W-1:0] o_y_r;
  logic signed [CHR_W-1:0]  o_cr_r, o_cb_r, o_dg_r;
  logic                     o_last_r;

  logic                     s2_ready, s1_take;
  logic [PIX_W:0]           sum1, sum2;
  pix_t                     gg1, gg2;
  logic signed [CHR_W-1:0]  cr_nxt, cb_nxt, dg_nxt;
  logic signed [LUMA_W-1:0] ccsum;
  logic signed [CHR_W-1:0]  half;
  logic signed [LUMA_W-1:0] y_nxt;

  assign s2_ready  = !o_valid_r || out_ready;
  assign job_ready = !s1_valid_r || s2_ready;
  assign s1_take   = job_valid && job_ready;

  always_comb begin
    sum1   = {1'b0, job.g1} + {1'b0, job.n1};
    sum2   = {1'b0, job.g2} + {1'b0, job.n2};
    gg1    = sum1[PIX_W:1];
    gg2    = sum2[PIX_W:1];
    cr_nxt = $signed({1'b0, job.r})  - $signed({1'b0, gg1});
    cb_nxt = $signed({1'b0, job.b})  - $signed({1'b0, gg2});
    dg_nxt = $signed({1'b0, job.g2}) - $signed({1'b0, job.g1});

    ccsum  = $signed({s1_cr_r[CHR_W-1], s1_cr_r}) + $signed({s1_cb_r[CHR_W-1], s1_cb_r});
    half   = ccsum[LUMA_W-1:1];   // floor halving
    y_nxt  = $signed({2'b00, s1_g1_r}) + $signed({half[CHR_W-1], half});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (job_ready) begin
        s1_valid_r <= job_valid;
      end
      if (s2_ready) begin
        o_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_cr_r   <= cr_nxt;
      s1_cb_r   <= cb_nxt;
      s1_dg_r   <= dg_nxt;
      s1_g1_r   <= job.g1;
      s1_last_r <= job.last;
    end
    if (s2_ready && s1_valid_r) begin
      o_y_r    <= y_nxt;
      o_cr_r   <= s1_cr_r;
      o_cb_r   <= s1_cb_r;
      o_dg_r   <= s1_dg_r;
      o_last_r <= s1_last_r;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_luma        = o_y_r;
  assign out_green_diff  = o_dg_r;
  assign out_chroma_red  = o_cr_r;
  assign out_chroma_blue = o_cb_r;
  assign out_last_of_row = o_last_r;

endmodule

/* sv/bayer_quad_to_ycc_forward.sv */
// Bayer quad to Y/dG/Cr/Cb forward transform, streamed one 2x2 quad per clock while
// in_ready is high. The block takes one quad per cycle unless the queue is full or a
// second result is held; a quad's result waits for the next quad, so the first quad of a
// row gives nothing and the last gives two results, and the row-end quad that follows a
// pending quad holds in_ready low while the front end issues its second result. A result
// passes from the transfer that releases it into the two-entry queue between front and
// back end, then through the arithmetic stage and the output register. The second result
// of a row end follows the first.
// cfg_data sets the CFA pattern: bit 1 puts the blue line on top, bit 0 puts green on the
// left of the red line. Write it only between transfers with no results outstanding.
module bayer_quad_to_ycc_forward import bqy_pkg::*; #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [PIX_W-1:0]         in_top_left,
  input  logic [PIX_W-1:0]         in_top_right,
  input  logic [PIX_W-1:0]         in_bottom_left,
  input  logic [PIX_W-1:0]         in_bottom_right,
  input  logic                     in_row_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [LUMA_W-1:0] out_luma,
  output logic signed [CHR_W-1:0]  out_green_diff,
  output logic signed [CHR_W-1:0]  out_chroma_red,
  output logic signed [CHR_W-1:0]  out_chroma_blue,
  output logic                     out_last_of_row
);

  localparam int   USED_BITS = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam pix_t PIX_MASK  = PIX_W'((64'd1 << USED_BITS) - 64'd1);

  cfa_t        cfa_r;
  quad_t       quad;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj, bj;
  front_stat_t fstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfa_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cfa_r <= cfg_data;
    end
  end

  assign quad.tl = in_top_left     & PIX_MASK;
  assign quad.tr = in_top_right    & PIX_MASK;
  assign quad.bl = in_bottom_left  & PIX_MASK;
  assign quad.br = in_bottom_right & PIX_MASK;

  bqy_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfa       (cfa_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_quad   (quad),
    .in_row_end(in_row_end),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj),
    .stat      (fstat)
  );

  bqy_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fj_valid),
    .wr_ready(fj_ready),
    .wr_job  (fj),
    .rd_valid(bj_valid),
    .rd_ready(bj_ready),
    .rd_job  (bj)
  );

  bqy_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (bj_valid),
    .job_ready      (bj_ready),
    .job            (bj),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_luma       (out_luma),
    .out_green_diff (out_green_diff),
    .out_chroma_red (out_chroma_red),
    .out_chroma_blue(out_chroma_blue),
    .out_last_of_row(out_last_of_row)
  );

  // a row-end transfer behind a pending quad must park its second result
  a_rowend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_row_end && fstat.pending |=> fstat.hold && !in_ready)
    else $error("row-end second result not held");

  a_rowend_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_row_end |=> !fstat.pending)
    else $error("quad left pending after row end");

  a_mid_row_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_row_end |=> fstat.pending && !fstat.hold)
    else $error("mid-row quad not pending");

endmodule
